[rtl/core/kdim_pkg.sv]
// Shared types, sizes and helpers for the key to dense index map.
// No dependencies; imported by every module of the block except the checker.
`timescale 1ns / 1ps

package kdim_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 256;
   localparam int TABLE_COUNT   = 4;

   localparam int SLOT_W    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
   localparam int TBL_W     = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int ADDR_W    = TBL_W + SLOT_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   // fixed field widths
   localparam int KEY_W   = 64;
   localparam int SEL_W   = 2;
   localparam int FIELD_W = 16;
   localparam int DIDX_W  = 8;

   // request codes and table ids
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;
   localparam logic [SEL_W-1:0] SEL_STATE = 2'd3;

   localparam logic [CNT_W-1:0]  ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(TABLE_ENTRIES - 1);

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [TBL_W-1:0]  tbl_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // one hash slot: stored key and the dense index it was given
   typedef struct packed {
      key_type  key;
      slot_type idx;
   } hash_entry_type;

   // sequencer to slot store
   typedef struct packed {
      logic           hash_rd_en;
      addr_type       hash_rd_addr;
      logic           hash_wr_en;
      addr_type       hash_wr_addr;
      hash_entry_type hash_wr_data;
      logic           dense_rd_en;
      addr_type       dense_rd_addr;
      logic           dense_wr_en;
      addr_type       dense_wr_addr;
      slot_type       dense_wr_slot;
   } mem_req_type;

   // slot store to sequencer (registered read data)
   typedef struct packed {
      hash_entry_type entry;
      slot_type       dense_slot;
   } mem_rsp_type;

   // xor fold of the key into a home slot, reduced into the table range
   function automatic slot_type hash_slot(input key_type k);
      slot_type h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % SLOT_W] = h[i % SLOT_W] ^ k[i];
      end
      if (h > LAST_SLOT) begin
         h = h - SLOT_W'(TABLE_ENTRIES);
      end
      return h;
   endfunction

endpackage

[rtl/core/kdim_slot_store.sv]
// Slot store: hash slot memory (key, dense index) and dense memory (index -> slot).
// Depends on kdim_pkg. One write and one registered read per memory per cycle.
`timescale 1ns / 1ps

module kdim_slot_store (
   input  logic                 clock,
   input  kdim_pkg::mem_req_type mem_req,
   output kdim_pkg::mem_rsp_type mem_rsp
);
   import kdim_pkg::*;

   hash_entry_type hash_mem [MEM_DEPTH];
   slot_type       dense_mem [MEM_DEPTH];

   hash_entry_type hash_rd_ff;
   slot_type       dense_rd_ff;

   // hash slot memory
   always_ff @(posedge clock) begin
      if (mem_req.hash_wr_en) begin
         hash_mem[mem_req.hash_wr_addr] <= mem_req.hash_wr_data;
      end
      if (mem_req.hash_rd_en) begin
         hash_rd_ff <= hash_mem[mem_req.hash_rd_addr];
      end
   end

   // dense back-pointer memory
   always_ff @(posedge clock) begin
      if (mem_req.dense_wr_en) begin
         dense_mem[mem_req.dense_wr_addr] <= mem_req.dense_wr_slot;
      end
      if (mem_req.dense_rd_en) begin
         dense_rd_ff <= dense_mem[mem_req.dense_rd_addr];
      end
   end

   assign mem_rsp.entry      = hash_rd_ff;
   assign mem_rsp.dense_slot = dense_rd_ff;

endmodule

[rtl/core/kdim_seq.sv]
// Probe sequencer: linear probing over the slot store, per-table counts,
// insert on miss, and the result register. Depends on kdim_pkg.
`timescale 1ns / 1ps

module kdim_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic [1:0]             req_table_select,
   input  kdim_pkg::key_type      lookup_key,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_dense_index,
   output logic                   rsp_was_new,
   output logic                   rsp_table_full,
   output kdim_pkg::mem_req_type  mem_req,
   input  kdim_pkg::mem_rsp_type  mem_rsp
);
   import kdim_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_CHK_HASH, ST_CHK_DENSE, ST_DONE} state_type;

   state_type state_ff, state_in;
   tbl_type   tbl_ff, tbl_in;
   key_type   key_ff, key_in;
   slot_type  slot_ff, slot_in;
   slot_type  probe_ff, probe_in;
   cnt_type   count_ff [TABLE_COUNT];
   cnt_type   count_in [TABLE_COUNT];
   slot_type  res_idx_ff, res_idx_in;
   logic      res_new_ff, res_new_in;
   logic      res_full_ff, res_full_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [DIDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic      rsp_new_ff, rsp_new_in;
   logic      rsp_full_ff, rsp_full_in;

   cnt_type   cur_cnt;
   logic      do_insert;
   slot_type  next_slot;
   slot_type  home_slot;

   assign cur_cnt   = count_ff[tbl_ff];
   assign next_slot = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign home_slot = hash_slot(lookup_key);
   assign req_stall = (state_ff != ST_IDLE);

   // next state, memory requests, insert and result staging
   always_comb begin
      state_in     = state_ff;
      tbl_in       = tbl_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      count_in     = count_ff;
      res_idx_in   = res_idx_ff;
      res_new_in   = res_new_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      mem_req      = '0;
      do_insert    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               tbl_in      = req_table_select[TBL_W-1:0];
               key_in      = lookup_key;
               slot_in     = home_slot;
               probe_in    = '0;
               res_idx_in  = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b0;
               if (req_type == REQ_CLEAR) begin
                  for (int t = 0; t < TABLE_COUNT; t++) begin
                     count_in[t] = '0;
                  end
                  state_in = ST_DONE;
               end else if (int'(req_table_select) >= TABLE_COUNT) begin
                  state_in = ST_DONE;
               end else begin
                  mem_req.hash_rd_en   = 1'b1;
                  mem_req.hash_rd_addr = {req_table_select[TBL_W-1:0], home_slot};
                  state_in             = ST_CHK_HASH;
               end
            end
         end
         ST_CHK_HASH: begin
            // slot may be live only if its index is below the fill count
            if (CNT_W'(mem_rsp.entry.idx) < cur_cnt) begin
               mem_req.dense_rd_en   = 1'b1;
               mem_req.dense_rd_addr = {tbl_ff, mem_rsp.entry.idx};
               state_in              = ST_CHK_DENSE;
            end else begin
               do_insert = 1'b1;
            end
         end
         ST_CHK_DENSE: begin
            // back-pointer confirms the slot was written since the last clear
            if (mem_rsp.dense_slot == slot_ff) begin
               if (mem_rsp.entry.key == key_ff) begin
                  res_idx_in = mem_rsp.entry.idx;
                  state_in   = ST_DONE;
               end else if (probe_ff == LAST_SLOT) begin
                  res_full_in = 1'b1;
                  state_in    = ST_DONE;
               end else begin
                  slot_in              = next_slot;
                  probe_in             = probe_ff + 1'b1;
                  mem_req.hash_rd_en   = 1'b1;
                  mem_req.hash_rd_addr = {tbl_ff, next_slot};
                  state_in             = ST_CHK_HASH;
               end
            end else begin
               do_insert = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = DIDX_W'(res_idx_ff);
               rsp_new_in   = res_new_ff;
               rsp_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // free slot found: insert if the table has room
      if (do_insert) begin
         if (cur_cnt < ENTRIES_CNT) begin
            mem_req.hash_wr_en        = 1'b1;
            mem_req.hash_wr_addr      = {tbl_ff, slot_ff};
            mem_req.hash_wr_data.key  = key_ff;
            mem_req.hash_wr_data.idx  = cur_cnt[SLOT_W-1:0];
            mem_req.dense_wr_en       = 1'b1;
            mem_req.dense_wr_addr     = {tbl_ff, cur_cnt[SLOT_W-1:0]};
            mem_req.dense_wr_slot     = slot_ff;
            count_in[tbl_ff]          = cur_cnt + 1'b1;
            res_idx_in                = cur_cnt[SLOT_W-1:0];
            res_new_in                = 1'b1;
         end else begin
            res_full_in = 1'b1;
         end
         state_in = ST_DONE;
      end
   end

   // state, counts and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TABLE_COUNT; t++) begin
            count_ff[t] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      tbl_ff      <= tbl_in;
      key_ff      <= key_in;
      slot_ff     <= slot_in;
      probe_ff    <= probe_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dense_index = rsp_idx_ff;
   assign rsp_was_new     = rsp_new_ff;
   assign rsp_table_full  = rsp_full_ff;

endmodule

[rtl/core/key_to_dense_index_map.sv]
// Flow: a hit reads the hash slot and then its back-pointer before the result is loaded;
// a miss fills a free slot; clear or unbuilt table skips both reads; each further probe repeats them.
// Throughput: one request at a time; the next beat is taken the cycle after the result
// is loaded, set by the hash-slot / back-pointer memory read loop of the sequencer.
// Reset: synchronous, clears counts and control; no memory sweep, liveness of a slot
// is proven by its index being below the fill count and the back-pointer matching.
`timescale 1ns / 1ps

module key_to_dense_index_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [1:0]  req_table_select,
   input  logic [63:0] req_key,
   input  logic [15:0] req_blend_index,
   input  logic [15:0] req_raster_index,
   input  logic [15:0] req_depth_stencil_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_dense_index,
   output logic        rsp_was_new,
   output logic        rsp_table_full
);
   import kdim_pkg::*;

   key_type     lookup_key;
   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   // render state table packs its key from the three state indices
   assign lookup_key = (req_table_select == SEL_STATE) ?
                       {{(KEY_W - 3*FIELD_W){1'b0}}, req_raster_index,
                        req_blend_index, req_depth_stencil_index} :
                       req_key;

   kdim_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_table_select (req_table_select),
      .lookup_key       (lookup_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dense_index  (rsp_dense_index),
      .rsp_was_new      (rsp_was_new),
      .rsp_table_full   (rsp_table_full),
      .mem_req          (mem_req),
      .mem_rsp          (mem_rsp)
   );

   kdim_slot_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

endmodule

[rtl/core/kdim_checker.sv]
// Port-level checks for key_to_dense_index_map, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module kdim_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_dense_index,
   input logic       rsp_was_new,
   input logic       rsp_table_full
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dense_index)
      && $stable(rsp_was_new) && $stable(rsp_table_full))
      else $error("stalled result beat changed");

   // one request at a time: busy right after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // insert and full miss are exclusive
   a_new_or_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_new && rsp_table_full))
      else $error("result both new and full");

   // full miss reports index zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_dense_index == 8'd0)
      else $error("full miss with nonzero index");

endmodule

bind key_to_dense_index_map kdim_checker u_kdim_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_dense_index (rsp_dense_index),
   .rsp_was_new     (rsp_was_new),
   .rsp_table_full  (rsp_table_full)
);
